### sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define AST_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/kms_pkg.sv
// Shared types and constants for the k-th largest magnitude selector.
package kms_pkg;

    localparam int DEPTH_DEF       = 1024;
    localparam int INDEX_WIDTH_DEF = 16;
    localparam int K_W             = 11;
    localparam logic [K_W-1:0] K_RESET = 11'd1;
    localparam int IN_DATA_W       = 96;
    localparam int OUT_DATA_W      = 96;
    localparam int OUT_USER_W      = 2;

    typedef enum logic [5:0] {
        S_LOAD  = 6'b000001,
        S_CHECK = 6'b000010,
        S_CAND  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_EVAL  = 6'b010000,
        S_NF    = 6'b100000
    } t_state;

    typedef struct packed {
        logic load;
        logic first;
        logic start_cand;
        logic scan;
        logic next_cand;
        logic cap_found;
        logic cap_nf;
    } t_cmd;

    typedef struct packed {
        logic last_in;
        logic k_ok;
        logic scan_done;
        logic rank_hit;
        logic last_cand;
        logic out_free;
    } t_status;

endpackage

### sv/kms_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### sv/kms_ctrl.sv
// Sequencer for load, rank scan and result capture.
module kms_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  kms_pkg::t_status i_st,
    output kms_pkg::t_cmd    o_cmd
);
    kms_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kms_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            kms_pkg::S_LOAD: begin
                o_cmd.load = 1'b1;
                if (i_st.last_in) begin
                    n_state = kms_pkg::S_CHECK;
                end
            end
            kms_pkg::S_CHECK: begin
                if (i_st.k_ok) begin
                    o_cmd.first = 1'b1;
                    n_state     = kms_pkg::S_CAND;
                end else begin
                    n_state = kms_pkg::S_NF;
                end
            end
            kms_pkg::S_CAND: begin
                o_cmd.start_cand = 1'b1;
                n_state          = kms_pkg::S_SCAN;
            end
            kms_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_st.scan_done) begin
                    n_state = kms_pkg::S_EVAL;
                end
            end
            kms_pkg::S_EVAL: begin
                if (i_st.rank_hit) begin
                    if (i_st.out_free) begin
                        o_cmd.cap_found = 1'b1;
                        n_state         = kms_pkg::S_LOAD;
                    end
                end else if (i_st.last_cand) begin
                    n_state = kms_pkg::S_NF;
                end else begin
                    o_cmd.next_cand = 1'b1;
                    n_state         = kms_pkg::S_CAND;
                end
            end
            kms_pkg::S_NF: begin
                if (i_st.out_free) begin
                    o_cmd.cap_nf = 1'b1;
                    n_state      = kms_pkg::S_LOAD;
                end
            end
            default: begin
                n_state = kms_pkg::S_LOAD;
            end
        endcase
    end
endmodule

### sv/kms_dp.sv
// Datapath: entry stores, rank counters and output register.
module kms_dp #(
    parameter int DEPTH       = kms_pkg::DEPTH_DEF,
    parameter int INDEX_WIDTH = kms_pkg::INDEX_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  kms_pkg::t_cmd                   i_cmd,
    output kms_pkg::t_status                o_st,
    input  logic                            i_s_tvalid,
    input  logic [kms_pkg::IN_DATA_W-1:0]   i_s_tdata,
    input  logic                            i_s_tlast,
    input  logic                            i_cfg_wr_en,
    input  logic [kms_pkg::K_W-1:0]         i_cfg_wr_data,
    output logic                            o_m_tvalid,
    output logic [kms_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    output logic [kms_pkg::OUT_USER_W-1:0]  o_m_tuser,
    input  logic                            i_m_tready
);
    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CW    = (INDEX_WIDTH < 16) ? INDEX_WIDTH : 16;
    localparam int CMP_W = (CNT_W > kms_pkg::K_W) ? CNT_W : kms_pkg::K_W;
    localparam logic [15:0] COORD_MASK = 16'((17'd1 << CW) - 17'd1);

    logic [CNT_W-1:0]        r_count;
    logic                    r_ovf;
    logic [kms_pkg::K_W-1:0] r_k;
    logic [AW-1:0]           r_i;
    logic [CNT_W-1:0]        r_j;
    logic                    r_pv;
    logic [AW-1:0]           r_pj;
    logic [CNT_W-1:0]        r_beat;

    logic                    r_ovalid;
    logic [31:0]             r_oval;
    logic [31:0]             r_omag;
    logic [15:0]             r_orow;
    logic [15:0]             r_ocol;
    logic                    r_ofound;
    logic                    r_oovf;

    logic                    full;
    logic                    accept;
    logic                    wr;
    logic [94:0]             a_wdata;
    logic [94:0]             a_rdata;
    logic [30:0]             b_rdata;
    logic [30:0]             cand_mag;
    logic                    beats;
    logic                    issue;
    logic [CMP_W-1:0]        k_ext;
    logic [CMP_W-1:0]        cnt_ext;
    logic                    out_free;

    assign full    = (r_count == CNT_W'(DEPTH));
    assign accept  = i_s_tvalid && i_cmd.load;
    assign wr      = accept && !full;
    // record: value, magnitude, row, column from the lowest bit up
    assign a_wdata = {i_s_tdata[94:79] & COORD_MASK, i_s_tdata[78:63] & COORD_MASK,
                      i_s_tdata[62:32], i_s_tdata[31:0]};

    kms_ram #(.WIDTH(95), .DEPTH(DEPTH)) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (wr),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (a_wdata),
        .i_raddr (r_i),
        .o_rdata (a_rdata)
    );

    kms_ram #(.WIDTH(31), .DEPTH(DEPTH)) u_mag_ram (
        .i_clk   (i_clk),
        .i_we    (wr),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_s_tdata[62:32]),
        .i_raddr (r_j[AW-1:0]),
        .o_rdata (b_rdata)
    );

    assign cand_mag = a_rdata[62:32];
    // an entry beats the candidate if larger, or equal and loaded earlier
    assign beats    = r_pv && ((b_rdata > cand_mag) || ((b_rdata == cand_mag) && (r_pj < r_i)));
    assign issue    = (r_j < r_count);
    assign k_ext    = CMP_W'(r_k);
    assign cnt_ext  = CMP_W'(r_count);
    assign out_free = !r_ovalid || i_m_tready;

    always_comb begin
        o_st.last_in   = i_s_tvalid && i_s_tlast;
        o_st.k_ok      = (k_ext != '0) && (k_ext <= cnt_ext);
        o_st.scan_done = (r_j == r_count) && !r_pv;
        o_st.rank_hit  = ((CMP_W'(r_beat) + CMP_W'(1)) == k_ext);
        o_st.last_cand = ((CNT_W'(r_i) + CNT_W'(1)) >= r_count);
        o_st.out_free  = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_k      <= kms_pkg::K_RESET;
            r_ovalid <= 1'b0;
            r_pv     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_k <= i_cfg_wr_data;
            end
            if (accept) begin
                if (full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (i_cmd.start_cand) begin
                r_pv <= 1'b0;
            end else if (i_cmd.scan) begin
                r_pv <= issue;
            end
            if (i_cmd.cap_found || i_cmd.cap_nf) begin
                r_ovalid <= 1'b1;
                r_count  <= '0;
                r_ovf    <= 1'b0;
            end else if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.first) begin
            r_i <= '0;
        end else if (i_cmd.next_cand) begin
            r_i <= r_i + AW'(1);
        end
        if (i_cmd.start_cand) begin
            r_j    <= '0;
            r_beat <= '0;
        end else if (i_cmd.scan) begin
            if (issue) begin
                r_j <= r_j + CNT_W'(1);
            end
            r_pj <= r_j[AW-1:0];
            if (beats) begin
                r_beat <= r_beat + CNT_W'(1);
            end
        end
        if (i_cmd.cap_found) begin
            r_oval   <= a_rdata[31:0];
            r_omag   <= {1'b0, a_rdata[62:32]};
            r_orow   <= a_rdata[78:63];
            r_ocol   <= a_rdata[94:79];
            r_ofound <= 1'b1;
            r_oovf   <= r_ovf;
        end else if (i_cmd.cap_nf) begin
            r_oval   <= '1;
            r_omag   <= '1;
            r_orow   <= '0;
            r_ocol   <= '0;
            r_ofound <= 1'b0;
            r_oovf   <= r_ovf;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {r_ocol, r_orow, r_omag, r_oval};
    assign o_m_tuser  = {r_oovf, r_ofound};
endmodule

### sv/kth_largest_magnitude_select.sv
// Top level of the k-th largest magnitude selector.
//
// Input stream: one sparse entry per transaction, tlast marks the final entry
// of a set. Entries load into on-chip stores at one per cycle. Entries past
// DEPTH are dropped and flag overflow on the result.
// After the last entry the block stops taking input (tready low) and ranks
// candidates in load order: for each candidate, one memory read port streams
// all n stored magnitudes against it. A rank out of range skips the scan.
// One result transaction follows each set: value, magnitude, row, column in
// tdata, found and overflow in tuser. The result sits in an output register;
// if the receiver stalls the block holds it and may load the next set, but
// the next result waits until the register is free.
// k_rank is written through the configuration port; it must be written only
// while idle, which the block itself does not enforce. Reset sets it to 1,
// empties the set and drops any pending result. Stores need no clearing after reset.
module kth_largest_magnitude_select #(
    parameter int DEPTH       = kms_pkg::DEPTH_DEF,
    parameter int INDEX_WIDTH = kms_pkg::INDEX_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // value[31:0], magnitude[62:32], row[78:63], col[94:79], zero pad
    input  logic [kms_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    input  logic                            i_s_axis_tlast,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // value[31:0], magnitude[63:32], row[79:64], col[95:80]
    output logic [kms_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // found[0], overflow[1]
    output logic [kms_pkg::OUT_USER_W-1:0]  o_m_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    input  logic                            i_cfg_wr_en,
    input  logic [kms_pkg::K_W-1:0]         i_cfg_wr_data
);
    kms_pkg::t_cmd    cmd;
    kms_pkg::t_status st;

    kms_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    kms_dp #(.DEPTH(DEPTH), .INDEX_WIDTH(INDEX_WIDTH)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_st          (st),
        .i_s_tvalid    (i_s_axis_tvalid),
        .i_s_tdata     (i_s_axis_tdata),
        .i_s_tlast     (i_s_axis_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_m_tvalid    (o_m_axis_tvalid),
        .o_m_tdata     (o_m_axis_tdata),
        .o_m_tuser     (o_m_axis_tuser),
        .i_m_tready    (i_m_axis_tready)
    );

    // input is taken only while loading
    assign o_s_axis_tready = cmd.load;

`include "assert_macros.svh"

    // capture only into a free output register
    `AST_IMPL(a_cap_free, i_clk, i_rst_n, cmd.cap_found || cmd.cap_nf, st.out_free)
    // a capture always shows a result next cycle
    `AST_NEXT(a_cap_valid, i_clk, i_rst_n, cmd.cap_found || cmd.cap_nf, o_m_axis_tvalid)
    // a miss carries magnitude -1
    `AST_IMPL(a_nf_mag, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser[0],
              o_m_axis_tdata[63:32] == 32'hFFFF_FFFF)
    // a hit carries a non-negative magnitude
    `AST_IMPL(a_hit_mag, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0],
              !o_m_axis_tdata[63])
endmodule
